### design/sawc_pkg.sv
`default_nettype none
package sawc_pkg;

	localparam int SAWC_WAYS = 4;
	// set index is taken straight from the address bits above the word select,
	// so the set count stays a power of two
	localparam int SAWC_SETS = 2;
	localparam int SAWC_SET_W = (SAWC_SETS > 1) ? $clog2(SAWC_SETS) : 1;
	localparam int TAG_W = 28;
	localparam logic [7:0] MISS_LAT_RST = 8'd29;
	localparam logic [7:0] STALL_MAX = 8'hFF;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_STORE = 2'd1,
		ACT_FILL  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_LOAD_HIT  = 3'd0,
		KIND_STORE_HIT = 3'd1,
		KIND_STALL     = 3'd2,
		KIND_WRITEBACK = 3'd3,
		KIND_FILL_REQ  = 3'd4,
		KIND_FILL_DONE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOK   = 3'b010,
		ST_SECOND = 3'b100
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
		logic [31:0] store_data;
		logic [31:0] fill_word_low;
		logic [31:0] fill_word_high;
	} sawc_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] mem_address;
		logic [31:0] word_low;
		logic [31:0] word_high;
		logic        last;
	} sawc_result_t;

	typedef struct packed {
		logic load_in;
		logic lookup;
		logic second;
	} sawc_cmd_t;

	typedef struct packed {
		logic no_result;
		logic two_results;
		logic out_free;
	} sawc_stat_t;

endpackage
`default_nettype wire

### design/sawc_if.sv
`default_nettype none
interface sawc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] address;
	logic [31:0] store_data;
	logic [31:0] fill_word_low;
	logic [31:0] fill_word_high;
	modport source(output valid, action, address, store_data, fill_word_low, fill_word_high,
		input ready);
	modport sink(input valid, action, address, store_data, fill_word_low, fill_word_high,
		output ready);
endinterface

interface sawc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] mem_address;
	logic [31:0] word_low;
	logic [31:0] word_high;
	logic        last;
	modport source(output valid, kind, mem_address, word_low, word_high, last, input ready);
	modport sink(input valid, kind, mem_address, word_low, word_high, last, output ready);
endinterface

interface sawc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

### design/sawc_ctrl.sv
`default_nettype none
module sawc_ctrl import sawc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  sawc_stat_t stat,
	output sawc_cmd_t  cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (stat.no_result) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.lookup = 1'b1;
					state_d = stat.two_results ? ST_SECOND : ST_IDLE;
				end
			end
			ST_SECOND: begin
				if (stat.out_free) begin
					cmd.second = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### design/sawc_dp.sv
`default_nettype none
module sawc_dp import sawc_pkg::*; #(
	parameter int WAYS = SAWC_WAYS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  sawc_item_t   item,
	input  sawc_cmd_t    cmd,
	output sawc_stat_t   stat,
	output sawc_result_t result,
	output logic         result_valid,
	input  logic         result_ready,
	input  logic         cfg_valid,
	input  logic [7:0]   cfg_data,
	output logic         cfg_ready
);

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	typedef logic [WAY_W-1:0] way_t;
	typedef way_t [WAYS-1:0] order_t;

	sawc_item_t item_q;
	logic [TAG_W-1:0] tag_q [SAWC_SETS][WAYS];
	logic [31:0] data_q [SAWC_SETS][WAYS][2];
	logic [WAYS-1:0] valid_q [SAWC_SETS];
	logic [WAYS-1:0] dirty_q [SAWC_SETS];
	order_t lru_q [SAWC_SETS];
	logic [7:0] cnt_q;
	logic [7:0] lat_q;
	logic pend_valid_q;
	logic pend_store_q;
	way_t pend_way_q;
	logic out_valid_q;
	sawc_result_t out_q;

	logic [SAWC_SET_W-1:0] set_idx;
	logic [TAG_W-1:0] tag;
	logic word;
	logic hit;
	way_t hit_way;
	way_t victim;
	way_t rd_way;
	way_t touch_way;
	logic [31:0] rd_lo, rd_hi;
	logic is_acc, is_store, fill_ok, acc_hit, stall, replace, wb;
	order_t new_order;
	sawc_result_t look_res, freq_res;

	// move the way to the most recent end, shifting the younger ones down
	function automatic order_t touch(order_t ord, way_t way);
		order_t res;
		logic found;
		res = ord;
		found = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && ord[i] == way) found = 1'b1;
			if (found) res[i] = (i == WAYS - 1) ? way : ord[(i + 1) % WAYS];
		end
		return res;
	endfunction

	assign set_idx = item_q.address[3 +: SAWC_SET_W];
	assign tag = item_q.address[31:4];
	assign word = item_q.address[2];

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		// lowest matching way wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid_q[set_idx][w] && tag_q[set_idx][w] == tag) begin
				hit = 1'b1;
				hit_way = way_t'(w);
			end
		end
	end

	assign victim = lru_q[set_idx][0];
	assign rd_way = hit ? hit_way : victim;
	assign rd_lo = data_q[set_idx][rd_way][0];
	assign rd_hi = data_q[set_idx][rd_way][1];

	assign is_store = (item_q.action == ACT_STORE);
	assign is_acc = (item_q.action == ACT_LOAD) || is_store;
	assign fill_ok = (item_q.action == ACT_FILL) && pend_valid_q;
	assign acc_hit = is_acc && hit;
	assign stall = is_acc && !hit && (pend_valid_q || cnt_q < lat_q);
	assign replace = is_acc && !hit && !stall;
	assign wb = replace && valid_q[set_idx][victim] && dirty_q[set_idx][victim];

	assign touch_way = fill_ok ? pend_way_q : hit_way;
	assign new_order = touch(lru_q[set_idx], touch_way);

	assign stat.no_result = !(fill_ok || is_acc);
	assign stat.two_results = wb;
	assign stat.out_free = !out_valid_q || result_ready;

	always_comb begin
		freq_res = '0;
		freq_res.kind = KIND_FILL_REQ;
		freq_res.mem_address = {item_q.address[31:3], 3'b000};
		freq_res.last = 1'b1;

		look_res = '0;
		look_res.last = 1'b1;
		look_res.kind = KIND_STALL;
		if (fill_ok) begin
			look_res.kind = KIND_FILL_DONE;
		end else if (acc_hit) begin
			if (is_store) begin
				look_res.kind = KIND_STORE_HIT;
			end else begin
				look_res.kind = KIND_LOAD_HIT;
				look_res.word_low = rd_lo;
				look_res.word_high = rd_hi;
			end
		end else if (wb) begin
			look_res.kind = KIND_WRITEBACK;
			look_res.mem_address = {tag_q[set_idx][victim], set_idx[0], 3'b000};
			look_res.word_low = rd_lo;
			look_res.word_high = rd_hi;
			look_res.last = 1'b0;
		end else if (replace) begin
			look_res = freq_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SAWC_SETS; s++) begin
				valid_q[s] <= '0;
				dirty_q[s] <= '0;
				for (int w = 0; w < WAYS; w++) begin
					lru_q[s][w] <= way_t'(w);
				end
			end
			cnt_q <= '0;
			lat_q <= MISS_LAT_RST;
			pend_valid_q <= 1'b0;
			pend_store_q <= 1'b0;
			pend_way_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) lat_q <= cfg_data;
			if (cmd.lookup || cmd.second) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.lookup) begin
				if (fill_ok) begin
					valid_q[set_idx][pend_way_q] <= 1'b1;
					dirty_q[set_idx][pend_way_q] <= pend_store_q;
					lru_q[set_idx] <= new_order;
					pend_valid_q <= 1'b0;
				end else if (acc_hit) begin
					cnt_q <= '0;
					lru_q[set_idx] <= new_order;
					if (is_store) dirty_q[set_idx][hit_way] <= 1'b1;
				end else if (stall) begin
					if (!pend_valid_q && cnt_q != STALL_MAX) cnt_q <= cnt_q + 8'd1;
				end else if (replace) begin
					// victim leaves the set until its fill returns
					valid_q[set_idx][victim] <= 1'b0;
					dirty_q[set_idx][victim] <= 1'b0;
					pend_valid_q <= 1'b1;
					pend_store_q <= is_store;
					pend_way_q <= victim;
					cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) item_q <= item;
		if (cmd.lookup && fill_ok) begin
			tag_q[set_idx][pend_way_q] <= tag;
			data_q[set_idx][pend_way_q][0] <= item_q.fill_word_low;
			data_q[set_idx][pend_way_q][1] <= item_q.fill_word_high;
		end
		if (cmd.lookup && acc_hit && is_store) begin
			data_q[set_idx][hit_way][word] <= item_q.store_data;
		end
		if (cmd.lookup) begin
			out_q <= look_res;
		end else if (cmd.second) begin
			out_q <= freq_res;
		end
	end

	assign result = out_q;
	assign result_valid = out_valid_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

### design/set_assoc_writeback_lru_cache.sv
// Write-back, write-allocate set-associative cache with true LRU per set.
// req channel: one access item (load, store or fill data from memory).
// rsp channel: result items; kind tells load hit, store hit, stall, writeback,
//   fill request or fill done, and last marks the final result of an item.
// cfg channel: writes the miss latency register, always ready; write it only
//   while no item is in flight.
// An item is accepted in the idle state and moves to lookup in the next cycle;
// its first result is registered at the lookup, and a new item is taken only
// once the last result of the one before is registered. A replacement of a
// dirty victim gives two results (writeback, then fill request) and holds
// the next item until the fill request is registered. Fill with nothing
// pending gives no result. Results sit in one output register; while rsp
// stalls, the lookup waits and req is not ready once the next item has been
// taken. Reset clears valid and dirty bits, LRU order, the stall count and
// any pending fill, and sets the miss latency register to MISS_LAT_RST.
`default_nettype none
module set_assoc_writeback_lru_cache import sawc_pkg::*; #(
	parameter int WAYS = SAWC_WAYS
) (
	input  wire  clk,
	input  wire  arst_n,
	sawc_req_if.sink   req,
	sawc_rsp_if.source rsp,
	sawc_cfg_if.sink   cfg
);

	sawc_item_t item;
	sawc_cmd_t cmd;
	sawc_stat_t stat;
	sawc_result_t result;

	assign item.action = req.action;
	assign item.address = req.address;
	assign item.store_data = req.store_data;
	assign item.fill_word_low = req.fill_word_low;
	assign item.fill_word_high = req.fill_word_high;

	sawc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sawc_dp #(
		.WAYS (WAYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (rsp.valid),
		.result_ready (rsp.ready),
		.cfg_valid    (cfg.valid),
		.cfg_data     (cfg.data),
		.cfg_ready    (cfg.ready)
	);

	assign rsp.kind = result.kind;
	assign rsp.mem_address = result.mem_address;
	assign rsp.word_low = result.word_low;
	assign rsp.word_high = result.word_high;
	assign rsp.last = result.last;

endmodule
`default_nettype wire

### tb/tb_set_assoc_writeback_lru_cache.sv
module tb_set_assoc_writeback_lru_cache import sawc_pkg::*; ();

	localparam int WAY_W = $clog2(SAWC_WAYS);
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 10;
	localparam int POOL_N = 6;

	logic clk;
	logic arst_n;

	sawc_req_if req_if();
	sawc_rsp_if rsp_if();
	sawc_cfg_if cfg_if();

	set_assoc_writeback_lru_cache dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// predicted cache state
	logic [TAG_W-1:0] line_tag_q [SAWC_SETS][SAWC_WAYS];
	bit               line_valid_q [SAWC_SETS][SAWC_WAYS];
	bit               line_dirty_q [SAWC_SETS][SAWC_WAYS];
	logic [31:0]      line_word_q [SAWC_SETS][SAWC_WAYS][2];
	logic [WAY_W-1:0] lru_q [SAWC_SETS][SAWC_WAYS];
	logic [7:0]       stall_cnt;
	logic [7:0]       miss_lat;
	bit               fill_due;
	bit               fill_is_store;
	logic [WAY_W-1:0] fill_way;
	logic [31:0]      fill_addr;

	sawc_result_t rsp_due[$];
	kind_t        last_kind;
	int           last_count;

	int send_idle_pct;
	int rsp_stall_pct;
	int err_cnt;
	int items_sent;
	int results_seen;
	int kind_cnt [8];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
	endtask

	function automatic void queue_result(kind_t k, logic [31:0] addr, logic [31:0] lo,
			logic [31:0] hi, logic fin);
		sawc_result_t r;
		r.kind = k;
		r.mem_address = addr;
		r.word_low = lo;
		r.word_high = hi;
		r.last = fin;
		rsp_due.push_back(r);
		last_kind = k;
	endfunction

	// move a way to the most recent end of its set's order
	function automatic void make_recent(int s, logic [WAY_W-1:0] w);
		int pos;
		pos = -1;
		for (int i = 0; i < SAWC_WAYS; i++)
			if (pos < 0 && lru_q[s][i] == w)
				pos = i;
		if (pos < 0)
			return;
		for (int i = pos; i < SAWC_WAYS - 1; i++)
			lru_q[s][i] = lru_q[s][i + 1];
		lru_q[s][SAWC_WAYS - 1] = w;
	endfunction

	// updates the predicted state for one item, returns how many results it causes
	function automatic int apply_access(sawc_item_t it);
		int s;
		int hit;
		int n;
		logic [TAG_W-1:0] tg;
		logic [WAY_W-1:0] v;
		s = (it.address >> 3) % SAWC_SETS;
		tg = it.address[31:4];
		hit = -1;
		n = 0;
		if (it.action == ACT_NONE)
			return 0;
		if (it.action == ACT_FILL) begin
			if (!fill_due)
				return 0;
			v = fill_way;
			line_word_q[s][v][0] = it.fill_word_low;
			line_word_q[s][v][1] = it.fill_word_high;
			line_tag_q[s][v] = tg;
			line_valid_q[s][v] = 1'b1;
			line_dirty_q[s][v] = fill_is_store;
			make_recent(s, v);
			fill_due = 1'b0;
			queue_result(KIND_FILL_DONE, '0, '0, '0, 1'b1);
			return 1;
		end
		for (int w = 0; w < SAWC_WAYS; w++)
			if (hit < 0 && line_valid_q[s][w] && line_tag_q[s][w] == tg)
				hit = w;
		if (hit >= 0) begin
			v = WAY_W'(hit);
			stall_cnt = '0;
			make_recent(s, v);
			if (it.action == ACT_LOAD) begin
				queue_result(KIND_LOAD_HIT, '0, line_word_q[s][v][0], line_word_q[s][v][1], 1'b1);
			end else begin
				line_word_q[s][v][it.address[2]] = it.store_data;
				line_dirty_q[s][v] = 1'b1;
				queue_result(KIND_STORE_HIT, '0, '0, '0, 1'b1);
			end
			return 1;
		end
		// miss: count up unless a fill is already outstanding
		if (fill_due || stall_cnt < miss_lat) begin
			if (!fill_due && stall_cnt != STALL_MAX)
				stall_cnt++;
			queue_result(KIND_STALL, '0, '0, '0, 1'b1);
			return 1;
		end
		v = lru_q[s][0];
		if (line_valid_q[s][v] && line_dirty_q[s][v]) begin
			queue_result(KIND_WRITEBACK, {line_tag_q[s][v], s[0], 3'b000},
				line_word_q[s][v][0], line_word_q[s][v][1], 1'b0);
			n++;
		end
		line_valid_q[s][v] = 1'b0;
		line_dirty_q[s][v] = 1'b0;
		fill_due = 1'b1;
		fill_is_store = (it.action == ACT_STORE);
		fill_way = v;
		fill_addr = it.address;
		stall_cnt = '0;
		queue_result(KIND_FILL_REQ, {it.address[31:3], 3'b000}, '0, '0, 1'b1);
		return n + 1;
	endfunction

	function automatic sawc_item_t make_item(action_t act, logic [31:0] addr);
		sawc_item_t it;
		it.action = act;
		it.address = addr;
		it.store_data = $urandom;
		it.fill_word_low = $urandom;
		it.fill_word_high = $urandom;
		return it;
	endfunction

	// called and returns at a falling edge; valid stays high for a following item
	task automatic send_item(sawc_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= it.action;
		req_if.address <= it.address;
		req_if.store_data <= it.store_data;
		req_if.fill_word_low <= it.fill_word_low;
		req_if.fill_word_high <= it.fill_word_high;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		last_count = apply_access(it);
		if (last_count > 0)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(negedge clk);
		// an ignored fill may still be in the lookup stage
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_latency(logic [7:0] val);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		miss_lat = val;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// retry one access until it stops stalling, then return the line if a fill was requested
	task automatic miss_until_fill(action_t act, logic [31:0] addr);
		do
			send_item(make_item(act, addr));
		while (last_kind == KIND_STALL);
		if (last_kind == KIND_FILL_REQ)
			send_item(make_item(ACT_FILL, addr));
	endtask

	task automatic test_reset_latency();
		miss_until_fill(ACT_LOAD, 32'h0000_1230);
	endtask

	task automatic test_fill_and_hit();
		sawc_item_t it;
		write_latency(8'd0);
		send_item(make_item(ACT_LOAD, 32'h0000_0000));
		// miss while the fill is outstanding
		send_item(make_item(ACT_LOAD, 32'hFFFF_FFFC));
		it = make_item(ACT_FILL, 32'h0000_0003);
		it.fill_word_low = '0;
		it.fill_word_high = '1;
		send_item(it);
		send_item(make_item(ACT_LOAD, 32'h0000_0004));
		it = make_item(ACT_STORE, 32'h0000_0004);
		it.store_data = '1;
		send_item(it);
		it = make_item(ACT_STORE, 32'h0000_0000);
		it.store_data = '0;
		send_item(it);
		send_item(make_item(ACT_LOAD, 32'h0000_0002));
		// neither of these causes a result
		send_item(make_item(ACT_FILL, $urandom));
		send_item(make_item(ACT_NONE, $urandom));
	endtask

	task automatic test_eviction();
		logic [TAG_W-1:0] tg [4];
		tg[0] = '1;
		tg[1] = 28'h1;
		tg[2] = 28'h2;
		tg[3] = 28'h3;
		for (int i = 0; i < 4; i++)
			miss_until_fill(ACT_STORE, {tg[i], 4'b1100});
		// touch the oldest so the dirty line with tag 1 becomes the victim
		send_item(make_item(ACT_LOAD, {tg[0], 4'b1000}));
		miss_until_fill(ACT_LOAD, {28'h4, 4'b1000});
	endtask

	task automatic test_stall_count();
		write_latency(8'd2);
		send_item(make_item(ACT_LOAD, 32'h0000_0050));
		send_item(make_item(ACT_LOAD, 32'h0000_0050));
		// a hit clears the count
		send_item(make_item(ACT_LOAD, 32'h0000_0000));
		send_item(make_item(ACT_LOAD, 32'h0000_0050));
		send_item(make_item(ACT_LOAD, 32'h0000_0050));
		send_item(make_item(ACT_LOAD, 32'h0000_0050));
		// count must not move while the fill is outstanding
		send_item(make_item(ACT_STORE, 32'h0ABC_DE04));
		send_item(make_item(ACT_FILL, 32'h0000_0050));
		miss_until_fill(ACT_STORE, 32'h0ABC_DE04);
	endtask

	task automatic test_max_latency();
		write_latency(8'hFF);
		miss_until_fill(ACT_STORE, 32'h8000_0008);
	endtask

	task automatic test_random_traffic(int n_items, logic [7:0] lat, int send_pct,
			int stall_pct);
		logic [TAG_W-1:0] tags [POOL_N];
		sawc_item_t it;
		logic [31:0] miss_addr;
		action_t miss_act;
		bit retry_ok;
		int done;
		int roll;
		write_latency(lat);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
		tags[0] = '0;
		tags[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			tags[i] = TAG_W'($urandom);
		miss_addr = '0;
		miss_act = ACT_LOAD;
		retry_ok = 1'b0;
		done = 0;
		while (done < n_items) begin
			roll = $urandom_range(99);
			it = make_item(ACT_LOAD, $urandom);
			if (roll < 8) begin
				// noise: ignored items, or a fill aimed at a random line
				it.action = ($urandom_range(1) != 0) ? ACT_NONE : ACT_FILL;
			end else if (fill_due && roll < 50) begin
				it.action = ACT_FILL;
				it.address = fill_addr;
			end else if (!fill_due && retry_ok && roll < 45) begin
				it.action = miss_act;
				it.address = miss_addr;
			end else begin
				it.action = ($urandom_range(1) != 0) ? ACT_STORE : ACT_LOAD;
				it.address[31:4] = tags[$urandom_range(POOL_N - 1)];
			end
			send_item(it);
			if (last_count > 0) begin
				done++;
				if (last_kind == KIND_STALL && !fill_due) begin
					miss_addr = it.address;
					miss_act = action_t'(it.action);
					retry_ok = 1'b1;
				end else if (last_kind == KIND_FILL_REQ) begin
					retry_ok = 1'b0;
				end
			end
		end
	endtask

	always @(posedge clk) begin : rsp_check
		sawc_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			results_seen++;
			kind_cnt[rsp_if.kind]++;
			if (rsp_due.size() == 0) begin
				report_mismatch("result with none expected, kind", 32'(rsp_if.kind), '0);
			end else begin
				want = rsp_due.pop_front();
				if (rsp_if.kind !== want.kind)
					report_mismatch("kind", 32'(rsp_if.kind), 32'(want.kind));
				if (rsp_if.mem_address !== want.mem_address)
					report_mismatch("mem_address", rsp_if.mem_address, want.mem_address);
				if (rsp_if.word_low !== want.word_low)
					report_mismatch("word_low", rsp_if.word_low, want.word_low);
				if (rsp_if.word_high !== want.word_high)
					report_mismatch("word_high", rsp_if.word_high, want.word_high);
				if (rsp_if.last !== want.last)
					report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
			end
		end
	end

	initial begin : rsp_side
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no handshake for %0d cycles, %0d results outstanding", IDLE_LIMIT,
			rsp_due.size());
		$display("tb_set_assoc_writeback_lru_cache: errors");
		$finish;
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.action = ACT_NONE;
		req_if.address = '0;
		req_if.store_data = '0;
		req_if.fill_word_low = '0;
		req_if.fill_word_high = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		for (int s = 0; s < SAWC_SETS; s++)
			for (int w = 0; w < SAWC_WAYS; w++) begin
				line_valid_q[s][w] = 1'b0;
				line_dirty_q[s][w] = 1'b0;
				lru_q[s][w] = WAY_W'(w);
			end
		stall_cnt = '0;
		miss_lat = MISS_LAT_RST;
		fill_due = 1'b0;
		fill_is_store = 1'b0;
		fill_way = '0;
		fill_addr = '0;
		last_kind = KIND_STALL;
		last_count = 0;
		err_cnt = 0;
		items_sent = 0;
		results_seen = 0;
		foreach (kind_cnt[i])
			kind_cnt[i] = 0;
		send_idle_pct = 10;
		rsp_stall_pct = 59;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_latency();
		test_fill_and_hit();
		test_eviction();
		test_stall_count();
		test_max_latency();
		test_random_traffic(100, 8'($urandom_range(3)), 10, 59);
		test_random_traffic(100, 8'($urandom_range(12, 4)), 59, 10);
		test_random_traffic(100, 8'd1, 0, 0);
		drain();

		$display("ran %0d items, checked %0d results", items_sent, results_seen);
		$display("load hits %0d, store hits %0d, stalls %0d, writebacks %0d, fills %0d",
			kind_cnt[KIND_LOAD_HIT], kind_cnt[KIND_STORE_HIT], kind_cnt[KIND_STALL],
			kind_cnt[KIND_WRITEBACK], kind_cnt[KIND_FILL_DONE]);
		if (err_cnt == 0)
			$display("tb_set_assoc_writeback_lru_cache: clean");
		else
			$display("tb_set_assoc_writeback_lru_cache: errors");
		$finish;
	end

endmodule

### set_assoc_writeback_lru_cache.f
design/sawc_pkg.sv
design/sawc_if.sv
design/sawc_ctrl.sv
design/sawc_dp.sv
design/set_assoc_writeback_lru_cache.sv
tb/tb_set_assoc_writeback_lru_cache.sv
